### hw/rtl/priority_event_queue_scheduler_macros.svh
// Assertion helpers for the scheduler.
`ifndef PRIORITY_EVENT_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_EVENT_QUEUE_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define PES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define PES_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/pes_pkg.sv
`default_nettype none

package pes_pkg;

  localparam int PRIO_W      = 4;
  localparam int EVENT_W     = 16;
  localparam int STATUS_W    = 3;
  localparam int READY_W     = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_QUEUES  = 8;
  localparam int MAX_SLOTS   = 16;
  localparam int QUEUE_IDX_W = 3;
  localparam int SLOT_IDX_W  = 4;
  localparam int LAST_W      = 4;

  localparam logic KIND_POST = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STARTED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QLAST   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_POSTED      = 3'd0,
    ST_DISPATCHED  = 3'd1,
    ST_IDLE        = 3'd2,
    ST_FULL        = 3'd3,
    ST_NOT_STARTED = 3'd4
  } pes_status_e;

  typedef struct packed {
    logic                   wr_en;
    logic [QUEUE_IDX_W-1:0] wr_queue;
    logic [SLOT_IDX_W-1:0]  wr_slot;
    logic                   rd_en;
    logic [QUEUE_IDX_W-1:0] rd_queue;
    logic [SLOT_IDX_W-1:0]  rd_slot;
  } pes_mem_req_t;

  typedef struct packed {
    pes_status_e        status;
    logic [PRIO_W-1:0]  dprio;
    logic [READY_W-1:0] ready;
  } pes_result_t;

endpackage

`default_nettype wire

### hw/rtl/pes_store.sv
`default_nettype none

module pes_store import pes_pkg::*; #(
  parameter int NUM_Q  = 8,
  parameter int SLOTS  = 16,
  parameter int DATA_W = 16
) (
  input  wire logic              clk_i,
  input  wire pes_mem_req_t      req_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  localparam int Depth = NUM_Q * SLOTS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DATA_W-1:0] mem [Depth];
  logic [AddrW-1:0]  waddr;
  logic [AddrW-1:0]  raddr;
  logic [DATA_W-1:0] rdata_q;

  assign waddr = AddrW'(int'(req_i.wr_queue) * SLOTS + int'(req_i.wr_slot));
  assign raddr = AddrW'(int'(req_i.rd_queue) * SLOTS + int'(req_i.rd_slot));

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[waddr] <= wdata_i;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/pes_ctrl.sv
`default_nettype none

module pes_ctrl import pes_pkg::*; #(
  parameter int NUM_Q = 8,
  parameter int SLOTS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  fire_i,
  input  wire logic                  kind_i,
  input  wire logic [PRIO_W-1:0]     prio_i,
  output pes_result_t                result_o,
  output pes_mem_req_t               mem_req_o
);

  localparam int QiW   = (NUM_Q > 1) ? $clog2(NUM_Q) : 1;
  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW  = $clog2(SLOTS + 1);

  logic [SlotW-1:0]      wpos_q [NUM_Q];
  logic [SlotW-1:0]      rpos_q [NUM_Q];
  logic [CntW-1:0]       fill_q [NUM_Q];
  logic [NUM_Q-1:0]      ready_q;
  logic [NUM_Q-1:0]      ready_d;
  logic [READY_W-1:0]    started_q;
  logic [CFG_DATA_W-1:0] qlast_q;

  logic [PRIO_W-1:0] prio_m1;
  logic              prio_ok;
  logic              prio_started;
  logic [QiW-1:0]    top_idx;
  logic [QiW-1:0]    sel;
  logic [LAST_W-1:0] field;
  logic [SlotW-1:0]  last;
  logic [CntW-1:0]   fill;
  logic [SlotW-1:0]  wpos;
  logic [SlotW-1:0]  rpos;
  logic [SlotW-1:0]  wstep;
  logic [SlotW-1:0]  rstep;
  logic              do_post;
  logic              do_pop;
  pes_status_e       status;
  logic [PRIO_W-1:0] dprio;

  assign prio_m1      = prio_i - 4'd1;
  assign prio_ok      = (prio_i != '0) && (prio_i <= PRIO_W'(NUM_Q));
  assign prio_started = started_q[prio_m1[QUEUE_IDX_W-1:0]];

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_Q; i++) begin
      if (ready_q[i]) begin
        top_idx = QiW'(i);
      end
    end
  end

  assign sel   = (kind_i == KIND_TAKE) ? top_idx : prio_m1[QiW-1:0];
  assign field = qlast_q[LAST_W*sel +: LAST_W];
  assign last  = (field < LAST_W'(SLOTS - 1)) ? field[SlotW-1:0] : SlotW'(SLOTS - 1);
  assign fill  = fill_q[sel];
  assign wpos  = wpos_q[sel];
  assign rpos  = rpos_q[sel];
  assign wstep = (wpos == '0) ? last : wpos - 1'b1;
  assign rstep = (rpos == '0) ? last : rpos - 1'b1;

  always_comb begin
    status  = ST_IDLE;
    dprio   = '0;
    ready_d = ready_q;
    do_post = 1'b0;
    do_pop  = 1'b0;
    if (kind_i == KIND_POST) begin
      if (!prio_ok || !prio_started) begin
        status = ST_NOT_STARTED;
      end else if (fill > CntW'(last)) begin
        status = ST_FULL;
      end else begin
        do_post      = 1'b1;
        ready_d[sel] = 1'b1;
        status       = ST_POSTED;
      end
    end else if (ready_q != '0) begin
      if (fill == '0) begin
        ready_d[sel] = 1'b0;
      end else begin
        do_pop = 1'b1;
        if (fill == CntW'(1)) begin
          ready_d[sel] = 1'b0;
        end
        dprio  = PRIO_W'(sel) + 4'd1;
        status = ST_DISPATCHED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   <= '0;
      started_q <= '0;
      qlast_q   <= '1;
      for (int i = 0; i < NUM_Q; i++) begin
        wpos_q[i] <= '0;
        rpos_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STARTED: begin
          for (int i = 0; i < NUM_Q; i++) begin
            if (cfg_data_i[i] && !started_q[i]) begin
              wpos_q[i]  <= '0;
              rpos_q[i]  <= '0;
              fill_q[i]  <= '0;
              ready_q[i] <= 1'b0;
            end
          end
          started_q <= cfg_data_i[READY_W-1:0];
        end
        CFG_QLAST: begin
          qlast_q <= cfg_data_i;
        end
      endcase
    end else if (fire_i) begin
      ready_q <= ready_d;
      if (do_post) begin
        wpos_q[sel] <= wstep;
        fill_q[sel] <= fill + 1'b1;
      end
      if (do_pop) begin
        rpos_q[sel] <= rstep;
        fill_q[sel] <= fill - 1'b1;
      end
    end
  end

  assign result_o.status = status;
  assign result_o.dprio  = dprio;
  assign result_o.ready  = READY_W'(ready_d);

  assign mem_req_o.wr_en    = fire_i && do_post;
  assign mem_req_o.wr_queue = QUEUE_IDX_W'(sel);
  assign mem_req_o.wr_slot  = SLOT_IDX_W'(wpos);
  assign mem_req_o.rd_en    = fire_i && do_pop;
  assign mem_req_o.rd_queue = QUEUE_IDX_W'(sel);
  assign mem_req_o.rd_slot  = SLOT_IDX_W'(rpos);

endmodule

`default_nettype wire

### hw/rtl/priority_event_queue_scheduler.sv
// Priority event scheduler with one event FIFO per priority.
// Slave stream: one item per transfer. tuser is the kind (post or take);
// tdata carries the target priority and the event handle of a post.
// Master stream: one result per accepted item, in order. tuser is the
// status; tdata carries the dispatched priority, the dispatched handle and
// the ready mask after the item.
// Configuration: write started_mask (index 0) or the packed queue lengths
// (index 1) while no item is in flight; starting a priority empties its
// queue.
// Pipeline: an item passes through the input register, then the result
// register with the event store read. Throughput is one item per cycle while
// the receiver does not stall; the event store takes one write or one read a cycle.
// Reset: all queues empty, no priority started, all lengths at maximum.
// When the receiver stalls, the result is held, one more item is taken
// into the input register, and then tready drops until the result leaves.
`default_nettype none
`include "priority_event_queue_scheduler_macros.svh"

module priority_event_queue_scheduler import pes_pkg::*; #(
  parameter int MAX_TASKS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,  // priority_req, event_handle
  input  wire logic                  s_axis_tuser,  // kind
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [31:0]           m_axis_tdata,  // dispatch_priority, dispatch_event, ready_bits
  output logic      [STATUS_W-1:0]   m_axis_tuser,  // status
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NumQ   = (MAX_TASKS < MAX_QUEUES) ? MAX_TASKS : MAX_QUEUES;
  localparam int Slots  = (QUEUE_DEPTH < MAX_SLOTS) ? QUEUE_DEPTH : MAX_SLOTS;
  localparam int StoreW = (EVENT_BITS < EVENT_W) ? EVENT_BITS : EVENT_W;

  logic               in_valid_q;
  logic               in_kind_q;
  logic [PRIO_W-1:0]  in_prio_q;
  logic [EVENT_W-1:0] in_event_q;
  logic               out_valid_q;
  pes_status_e        out_status_q;
  logic [PRIO_W-1:0]  out_dprio_q;
  logic [READY_W-1:0] out_ready_q;
  logic               adv;
  logic               fire;
  logic               in_xfer;
  pes_result_t        result;
  pes_mem_req_t       mem_req;
  logic [StoreW-1:0]  rdata;
  logic [EVENT_W-1:0] out_event;

  assign adv           = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_kind_q  <= s_axis_tuser;
      in_prio_q  <= s_axis_tdata[PRIO_W-1:0];
      in_event_q <= s_axis_tdata[PRIO_W +: EVENT_W];
    end
    if (fire) begin
      out_status_q <= result.status;
      out_dprio_q  <= result.dprio;
      out_ready_q  <= result.ready;
    end
  end

  pes_ctrl #(
    .NUM_Q(NumQ),
    .SLOTS(Slots)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .fire_i    (fire),
    .kind_i    (in_kind_q),
    .prio_i    (in_prio_q),
    .result_o  (result),
    .mem_req_o (mem_req)
  );

  pes_store #(
    .NUM_Q (NumQ),
    .SLOTS (Slots),
    .DATA_W(StoreW)
  ) u_store (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .wdata_i(StoreW'(in_event_q)),
    .rdata_o(rdata)
  );

  assign out_event     = (out_status_q == ST_DISPATCHED) ? EVENT_W'(rdata) : '0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {4'b0000, out_ready_q, out_event, out_dprio_q};

  `PES_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, fire, out_valid_q)
  `PES_ASSERT_SAME(a_dprio_only_on_dispatch, clk_i, rst_ni,
                   out_valid_q && (out_status_q != ST_DISPATCHED), out_dprio_q == '0)
  `PES_ASSERT_NEXT(a_post_sets_ready, clk_i, rst_ni,
                   fire && (result.status == ST_POSTED), out_ready_q != '0)
  `PES_ASSERT_NEXT(a_stalled_item_held, clk_i, rst_ni,
                   in_valid_q && !adv, in_valid_q && $stable(in_prio_q))

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import pes_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int RAND_ITEMS  = 90;

  typedef struct packed {
    logic               kind;
    logic [PRIO_W-1:0]  prio;
    logic [EVENT_W-1:0] handle;
  } sched_item_t;

  typedef struct packed {
    pes_status_e        status;
    logic [PRIO_W-1:0]  prio;
    logic [EVENT_W-1:0] ev;
    logic [READY_W-1:0] ready;
  } sched_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;  // priority_req, event_handle
  logic                  s_axis_tuser = 1'b0;  // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;  // dispatch_priority, dispatch_event, ready_bits
  logic [STATUS_W-1:0]   m_axis_tuser;  // status
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  priority_event_queue_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // scheduler state as predicted
  logic [EVENT_W-1:0]    ev_store [MAX_QUEUES][MAX_SLOTS];
  logic [SLOT_IDX_W-1:0] wr_pos [MAX_QUEUES];
  logic [SLOT_IDX_W-1:0] rd_pos [MAX_QUEUES];
  logic [4:0]            fill [MAX_QUEUES];
  logic [READY_W-1:0]    ready_m = '0;
  logic [7:0]            started_m = '0;
  logic [31:0]           qlast_m = '1;

  sched_item_t   pending_items[$];
  sched_result_t due_results[$];
  sched_item_t   drv_item;

  logic no_gaps = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done;
  int   hold_left;
  int   cycles = 0;
  int   fail_count = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   cfg_writes = 0;
  int   status_seen [5] = '{default: 0};

  initial begin
    foreach (fill[i]) begin
      wr_pos[i] = '0;
      rd_pos[i] = '0;
      fill[i]   = '0;
    end
  end

  function automatic logic [SLOT_IDX_W-1:0] slot_last(input int q);
    logic [LAST_W-1:0] f;
    f = qlast_m[4*q +: 4];
    return (f < MAX_SLOTS - 1) ? f : SLOT_IDX_W'(MAX_SLOTS - 1);
  endfunction

  function automatic sched_result_t schedule_item(input sched_item_t it);
    sched_result_t         r;
    int                    q;
    logic [SLOT_IDX_W-1:0] last;
    r.status = ST_IDLE;
    r.prio   = '0;
    r.ev     = '0;
    q        = -1;
    if (it.kind == KIND_POST) begin
      if (it.prio == 0 || it.prio > MAX_QUEUES || !started_m[it.prio - 1]) begin
        r.status = ST_NOT_STARTED;
      end else begin
        q = int'(it.prio) - 1;
        last = slot_last(q);
        if (fill[q] > last) begin
          r.status = ST_FULL;
        end else begin
          ev_store[q][wr_pos[q]] = it.handle;
          wr_pos[q] = (wr_pos[q] == 0) ? last : wr_pos[q] - 1'b1;
          fill[q] = fill[q] + 1'b1;
          ready_m[q] = 1'b1;
          r.status = ST_POSTED;
        end
      end
    end else begin
      for (int i = 0; i < MAX_QUEUES; i++) begin
        if (ready_m[i]) q = i;
      end
      if (q >= 0) begin
        if (fill[q] == 0) begin
          ready_m[q] = 1'b0;
        end else begin
          last = slot_last(q);
          r.ev = ev_store[q][rd_pos[q]];
          rd_pos[q] = (rd_pos[q] == 0) ? last : rd_pos[q] - 1'b1;
          fill[q] = fill[q] - 1'b1;
          if (fill[q] == 0) ready_m[q] = 1'b0;
          r.prio = PRIO_W'(q + 1);
          r.status = ST_DISPATCHED;
        end
      end
    end
    r.ready = ready_m;
    return r;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        due_results.push_back(schedule_item(drv_item));
        items_sent++;
      end
      if (pending_items.size() > 0 && (no_gaps || $urandom_range(99) >= 19)) begin
        drv_item = pending_items.pop_front();
        s_axis_tdata  <= {4'b0, drv_item.handle, drv_item.prio};
        s_axis_tuser  <= drv_item.kind;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    sched_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = pes_status_e'(m_axis_tuser);
      got.prio   = m_axis_tdata[3:0];
      got.ev     = m_axis_tdata[19:4];
      got.ready  = m_axis_tdata[27:20];
      results_seen++;
      if (due_results.size() == 0) begin
        if (fail_count < 10) $display("unexpected result: status %0d", m_axis_tuser);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        status_seen[int'(want.status)]++;
        if (got.status !== want.status || got.prio !== want.prio ||
            got.ev !== want.ev || got.ready !== want.ready) begin
          if (fail_count < 10) begin
            $display("mismatch at result %0d: status %0d/%0d prio %0d/%0d ev %h/%h ready %b/%b",
                     results_seen, want.status, got.status, want.prio, got.prio,
                     want.ev, got.ev, want.ready, got.ready);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[priority_event_queue_scheduler] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || due_results.size() != 0);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_STARTED) begin
      for (int i = 0; i < MAX_QUEUES; i++) begin
        if (val[i] && !started_m[i]) begin
          wr_pos[i]  = '0;
          rd_pos[i]  = '0;
          fill[i]    = '0;
          ready_m[i] = 1'b0;
        end
      end
      started_m = val[7:0];
    end else begin
      qlast_m = val;
    end
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_post(input logic [PRIO_W-1:0] p, input logic [EVENT_W-1:0] h);
    pending_items.push_back('{kind: KIND_POST, prio: p, handle: h});
  endtask

  task automatic push_take();
    pending_items.push_back('{kind: KIND_TAKE, prio: PRIO_W'($urandom),
                              handle: EVENT_W'($urandom)});
  endtask

  task automatic push_random(input int post_pct);
    logic [PRIO_W-1:0] p;
    if ($urandom_range(99) < post_pct) begin
      if ($urandom_range(9) == 0) p = $urandom_range(1) ? 4'd0 : PRIO_W'($urandom_range(15, 9));
      else p = PRIO_W'($urandom_range(8, 1));
      push_post(p, EVENT_W'($urandom));
    end else begin
      push_take();
    end
  endtask

  // empty every queue so the lengths can change safely
  task automatic drain_queues();
    int n;
    wait_idle();
    n = 0;
    foreach (fill[i]) n += fill[i];
    repeat (n) push_take();
    wait_idle();
  endtask

  initial begin : stimulus
    logic [7:0]  start_v;
    logic [31:0] qlast_v;
    int          pct;
    int          n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_take();
    push_post(4'd3, 16'h1234);
    wait_idle();
    write_cfg(CFG_STARTED, 32'h0000_00FF);
    write_cfg(CFG_QLAST, 32'hF000_0010);
    push_post(4'd1, 16'hFFFF);
    push_post(4'd1, 16'h0000);
    push_post(4'd0, 16'h1111);
    push_post(4'd9, 16'h2222);
    push_post(4'd15, 16'h3333);
    push_post(4'd8, 16'h0001);
    push_post(4'd8, 16'hFFFE);
    push_post(4'd2, 16'hAAAA);
    push_post(4'd2, 16'h5555);
    push_post(4'd2, 16'h0F0F);
    repeat (6) push_take();
    wait_idle();
    push_post(4'd5, 16'hC3C3);
    push_post(4'd5, 16'h3C3C);
    wait_idle();
    write_cfg(CFG_STARTED, 32'h0000_00EF);
    push_post(4'd5, 16'h0001);
    repeat (3) push_take();

    for (int ph = 0; ph < 8; ph++) begin
      drain_queues();
      start_v = 8'($urandom);
      qlast_v = $urandom;
      pct     = 55;
      n       = RAND_ITEMS;
      case (ph)
        0: begin start_v = 8'hFF; qlast_v = 32'hFFFF_FFFF; pct = 70; end
        1: begin start_v = 8'hFF; qlast_v = 32'h0000_0000; pct = 60; end
        3: begin start_v = 8'h00; pct = 50; n = 30; end
        4: pct = 60;
        5: begin start_v = 8'hFF; qlast_v = $urandom & 32'h3333_3333; end
        6: begin qlast_v = 32'hFFFF_FFFF; pct = 45; end
        default: ;
      endcase
      write_cfg(CFG_STARTED, {24'b0, start_v});
      write_cfg(CFG_QLAST, qlast_v);
      no_gaps = (ph == 2);
      if (ph == 4) hold_req = 1'b1;
      repeat (n) push_random(pct);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("%0d items, %0d results, %0d register writes", items_sent, results_seen,
             cfg_writes);
    $display("posted %0d dispatched %0d idle %0d full %0d not started %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("[priority_event_queue_scheduler] OK");
    end else begin
      $display("[priority_event_queue_scheduler] ERROR");
    end
    $finish;
  end

endmodule

### priority_event_queue_scheduler.f
+incdir+hw/rtl
hw/rtl/pes_pkg.sv
hw/rtl/pes_store.sv
hw/rtl/pes_ctrl.sv
hw/rtl/priority_event_queue_scheduler.sv
bench/tb.sv
